FILE: rtl/core/srlc_pkg.sv
package srlc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_UP       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_DOWN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NO_DATA       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_IDLE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_SLOW    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_FAST    = 3'd6;

    localparam logic [1:0] LVL_OFF  = 2'd0;
    localparam logic [1:0] LVL_ONE  = 2'd1;
    localparam logic [1:0] LVL_BOTH = 2'd2;

    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_READING = 1'b1;

    localparam logic [30:0] RST_STEP_UP       = 31'd3500;
    localparam logic [30:0] RST_STEP_DOWN     = 31'd300;
    localparam logic [19:0] RST_STEP_INTERVAL = 20'd10000;
    localparam logic [23:0] RST_NO_DATA       = 24'd300000;
    localparam logic [15:0] RST_BLINK_IDLE    = 16'd2000;
    localparam logic [15:0] RST_BLINK_SLOW    = 16'd500;
    localparam logic [15:0] RST_BLINK_FAST    = 16'd125;

    typedef struct packed {
        logic               command;
        logic signed [31:0] power_mw;
    } t_in_item;

    typedef struct packed {
        logic       relay_one;
        logic       relay_two;
        logic       led_on;
        logic [1:0] level;
        logic       changed;
    } t_out_item;

    typedef struct packed {
        logic [30:0] step_up_mw;
        logic [30:0] step_down_mw;
        logic [19:0] step_hold_ms;
        logic [23:0] silence_limit_ms;
        logic [15:0] led_period_off;
        logic [15:0] led_period_one;
        logic [15:0] led_period_two;
    } t_cfg;

endpackage

FILE: rtl/core/srlc_cfg_regs.sv
module srlc_cfg_regs
    import srlc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_index)
                REG_STEP_UP:       n_cfg.step_up_mw       = i_data[30:0];
                REG_STEP_DOWN:     n_cfg.step_down_mw     = i_data[30:0];
                REG_STEP_INTERVAL: n_cfg.step_hold_ms     = i_data[19:0];
                REG_NO_DATA:       n_cfg.silence_limit_ms = i_data[23:0];
                REG_BLINK_IDLE:    n_cfg.led_period_off   = i_data[15:0];
                REG_BLINK_SLOW:    n_cfg.led_period_one   = i_data[15:0];
                REG_BLINK_FAST:    n_cfg.led_period_two   = i_data[15:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_up_mw       <= RST_STEP_UP;
            r_cfg.step_down_mw     <= RST_STEP_DOWN;
            r_cfg.step_hold_ms     <= RST_STEP_INTERVAL;
            r_cfg.silence_limit_ms <= RST_NO_DATA;
            r_cfg.led_period_off   <= RST_BLINK_IDLE;
            r_cfg.led_period_one   <= RST_BLINK_SLOW;
            r_cfg.led_period_two   <= RST_BLINK_FAST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/core/srlc_core.sv
module srlc_core
    import srlc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_res
);

    logic [1:0]  r_level;
    logic [19:0] r_since_change_ms;
    logic [23:0] r_since_data_ms;
    logic [15:0] r_led_elapsed_ms;
    logic        r_led_state;

    logic [1:0]  n_level;
    logic [19:0] n_since_change_ms;
    logic [23:0] n_since_data_ms;
    logic [15:0] n_led_elapsed_ms;
    logic        n_led_state;
    logic        n_changed;

    logic [19:0] sc_inc;
    logic [23:0] sd_inc;
    logic [15:0] le_inc;
    logic [15:0] period;
    logic        below_down;
    logic        at_up;

    assign sc_inc = (r_since_change_ms == '1) ? r_since_change_ms : r_since_change_ms + 20'd1;
    assign sd_inc = (r_since_data_ms == '1) ? r_since_data_ms : r_since_data_ms + 24'd1;
    assign le_inc = (r_led_elapsed_ms == '1) ? r_led_elapsed_ms : r_led_elapsed_ms + 16'd1;

    assign below_down = i_item.power_mw[31] || (i_item.power_mw[30:0] < i_cfg.step_down_mw);
    assign at_up      = !i_item.power_mw[31] && (i_item.power_mw[30:0] >= i_cfg.step_up_mw);

    always_comb begin
        case (r_level)
            LVL_OFF: period = i_cfg.led_period_off;
            LVL_ONE: period = i_cfg.led_period_one;
            default: period = i_cfg.led_period_two;
        endcase
    end

    always_comb begin
        n_level           = r_level;
        n_since_change_ms = r_since_change_ms;
        n_since_data_ms   = r_since_data_ms;
        n_led_elapsed_ms  = r_led_elapsed_ms;
        n_led_state       = r_led_state;
        n_changed         = 1'b0;
        if (i_item.command == CMD_TICK) begin
            n_since_change_ms = sc_inc;
            n_since_data_ms   = sd_inc;
            n_led_elapsed_ms  = le_inc;
            if (le_inc >= period) begin
                n_led_state      = !r_led_state;
                n_led_elapsed_ms = '0;
            end
            if (sd_inc >= i_cfg.silence_limit_ms) begin
                n_changed       = (r_level != LVL_OFF);
                n_level         = LVL_OFF;
                n_since_data_ms = '0;
            end
        end else begin
            n_since_data_ms = '0;
            if (below_down && (r_level != LVL_OFF)) begin
                n_level           = r_level - 2'd1;
                n_since_change_ms = '0;
                n_changed         = 1'b1;
            end else if (at_up && (r_level != LVL_BOTH)
                         && (r_since_change_ms >= i_cfg.step_hold_ms)) begin
                n_level           = r_level + 2'd1;
                n_since_change_ms = '0;
                n_changed         = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level           <= LVL_OFF;
            r_since_change_ms <= '0;
            r_since_data_ms   <= '0;
            r_led_elapsed_ms  <= '0;
            r_led_state       <= 1'b0;
        end else if (i_en) begin
            r_level           <= n_level;
            r_since_change_ms <= n_since_change_ms;
            r_since_data_ms   <= n_since_data_ms;
            r_led_elapsed_ms  <= n_led_elapsed_ms;
            r_led_state       <= n_led_state;
        end
    end

    assign o_res.relay_one = (n_level != LVL_OFF);
    assign o_res.relay_two = (n_level == LVL_BOTH);
    assign o_res.led_on    = n_led_state;
    assign o_res.level     = n_level;
    assign o_res.changed   = n_changed;

    a_level_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level != 2'd3)
        else $error("relay level left its legal range");

    a_changed_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_res.changed) |=> (r_level != $past(r_level)))
        else $error("changed flagged without a level change");

    a_reading_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && (i_item.command == CMD_READING)) |=> (r_since_data_ms == '0))
        else $error("reading did not clear the no-data counter");

    a_step_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && (i_item.command == CMD_READING) && o_res.changed)
        |=> (r_since_change_ms == '0))
        else $error("level step did not clear the step counter");

endmodule

FILE: rtl/core/stepped_relay_load_controller.sv
// An item enters the input register; its result then enters the result register and is offered.
// One item per cycle unless stalled; the relay level and counters update once per item in one pass.
// A stalled result holds the result register, and the input register then holds one more item.
// Reset is synchronous and active low: relays off, all counters and the LED cleared,
// and every configuration register returns to its default value.
module stepped_relay_load_controller
    import srlc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic      r_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid;
    t_out_item r_out_data;

    t_cfg      cfg;
    t_out_item res;
    logic      s1_move;
    logic      in_accept;

    assign o_cfg_ready = 1'b1;
    assign s1_move     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_s1_valid && !s1_move;
    assign in_accept   = i_in_valid && !o_in_stall;

    srlc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    srlc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s1_move),
        .i_item  (r_s1_item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_move || !r_s1_valid) begin
                r_s1_valid <= in_accept;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item <= i_in_data;
        end
        if (s1_move) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
